FILE: rtl/core/gan_pkg.sv
// Package: shared types and constants for the grid A* node engine.
`default_nettype none
package gan_pkg;
	localparam int unsigned GRID_H = 8;
	localparam int unsigned GRID_W = 8;
	localparam int unsigned CELL_W = 6;
	localparam int unsigned COST_W = 14;
	localparam logic [COST_W-1:0] COST_MAX = 14'd16383;
	localparam logic [7:0] STEP_STRAIGHT = 8'd100;
	localparam logic [7:0] STEP_DIAG = 8'd141;

	typedef enum logic [1:0] {
		REQ_DISCOVER = 2'd0,
		REQ_CLOSE    = 2'd1,
		REQ_SELECT   = 2'd2,
		REQ_NONE     = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_WALL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	localparam logic [1:0] CFG_WALL   = 2'd0;
	localparam logic [1:0] CFG_START  = 2'd1;
	localparam logic [1:0] CFG_FINISH = 2'd2;

	typedef struct packed {
		logic [1:0] req_type;
		logic [CELL_W-1:0] current_cell;
		logic [CELL_W-1:0] neighbour_cell;
	} req_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [CELL_W-1:0] chosen_cell;
		logic [COST_W-1:0] chosen_cost;
	} rsp_item_t;

	typedef struct packed {
		logic [1:0] index;
		logic [63:0] data;
	} cfg_item_t;
endpackage
`default_nettype wire

FILE: rtl/core/gan_if.sv
// Interfaces: valid/ready channels for requests, results and configuration.
`default_nettype none
interface gan_req_if import gan_pkg::*; ();
	logic valid;
	logic ready;
	req_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface gan_rsp_if import gan_pkg::*; ();
	logic valid;
	logic ready;
	rsp_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface gan_cfg_if import gan_pkg::*; ();
	logic valid;
	logic ready;
	cfg_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/grid_astar_node_engine.sv
// Top level: A* node store with a sequencer walking the memories one entry at a time.
// One request at a time; the memory read ports set the pace.
// Reset: arst_n clears flags, open count, registers and sequencer; no clearing pass.
`default_nettype none
module grid_astar_node_engine import gan_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	gan_req_if.sink   req,
	gan_rsp_if.source rsp,
	gan_cfg_if.sink   cfg
);
	localparam int unsigned NCELLS = GRID_H * GRID_W;
	localparam int unsigned NW = $clog2(NCELLS);
	localparam int unsigned OCW = NW + 1;

	typedef enum logic [10:0] {
		S_IDLE   = 11'b00000000001,
		S_FIND   = 11'b00000000010, // scan open list for target
		S_FINDW  = 11'b00000000100,
		S_CHAIN  = 11'b00000001000, // read parent of walk cell
		S_CHAINW = 11'b00000010000,
		S_UPD    = 11'b00000100000,
		S_SHIFT  = 11'b00001000000, // close: compact open list
		S_SHIFTW = 11'b00010000000,
		S_SEL    = 11'b00100000000, // read open list entry
		S_SELW   = 11'b01000000000, // read its costs, compare
		S_OUT    = 11'b10000000000
	} state_t;

	state_t state_q;

	// configuration
	logic [63:0] wall_q;
	logic [CELL_W-1:0] start_q, finish_q;

	// per-cell flags, reset-cleared
	logic [NCELLS-1:0] disc_q, closed_q;
	logic [OCW-1:0] ocount_q;

	// memories
	logic [NW-1:0] parent_mem [NCELLS];
	logic [COST_W-1:0] g_mem [NCELLS];
	logic [COST_W-1:0] h_mem [NCELLS];
	logic [NW-1:0] open_mem [NCELLS];

	logic [NW-1:0] par_rd_q, open_rd_q;
	logic [COST_W-1:0] g_rd_q, h_rd_q;

	// request context
	logic [1:0] rt_q;
	logic [NW-1:0] cur_q, nb_q;
	logic [OCW-1:0] idx_q;
	logic [OCW:0] steps_q;
	logic found_q;
	logic [NW-1:0] pos_q;
	logic [NW-1:0] walk_q;
	logic [COST_W-1:0] sum_q;
	logic pass_q; // select: 0 finds min f, 1 finds tie winner
	logic [COST_W-1:0] bf_q, bh_q;
	logic bh_ok_q;
	logic [NW-1:0] best_q;
	logic [NW-1:0] sel_cell_q;
	rsp_item_t out_q;
	logic out_v_q;

	// cell index; the 6-bit field spans exactly the 64 cells
	function automatic logic [NW-1:0] cell_of(input logic [CELL_W-1:0] v);
		return v[NW-1:0];
	endfunction

	function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
			input logic [COST_W-1:0] b);
		logic [COST_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COST_W] ? COST_MAX : s[COST_W-1:0];
	endfunction

	logic [NW-1:0] a_c, b_c;
	logic [7:0] step_w;
	always_comb begin
		logic [NW:0] ar, ac, br, bc;
		a_c = walk_q;
		b_c = (walk_q == nb_q) ? cur_q : par_rd_q;
		ar = ({1'b0, a_c}) / (NW+1)'(GRID_W);
		ac = ({1'b0, a_c}) % (NW+1)'(GRID_W);
		br = ({1'b0, b_c}) / (NW+1)'(GRID_W);
		bc = ({1'b0, b_c}) % (NW+1)'(GRID_W);
		step_w = ((ar != br) && (ac != bc)) ? STEP_DIAG : STEP_STRAIGHT;
	end

	// heuristic of neighbour versus finish
	logic [COST_W-1:0] heur;
	always_comb begin
		logic [NW-1:0] fc;
		logic [NW:0] r, k, fr, fk, dr, dc, lo, hi;
		logic [NW+9:0] h;
		fc = cell_of(finish_q);
		r = ({1'b0, nb_q}) / (NW+1)'(GRID_W);
		k = ({1'b0, nb_q}) % (NW+1)'(GRID_W);
		fr = ({1'b0, fc}) / (NW+1)'(GRID_W);
		fk = ({1'b0, fc}) % (NW+1)'(GRID_W);
		dr = (r > fr) ? r - fr : fr - r;
		dc = (k > fk) ? k - fk : fk - k;
		lo = (dr < dc) ? dr : dc;
		hi = (dr < dc) ? dc : dr;
		h = (NW+10)'(lo) * (NW+10)'(STEP_DIAG) + (NW+10)'(hi - lo) * (NW+10)'(STEP_STRAIGHT);
		heur = (h > (NW+10)'(COST_MAX)) ? COST_MAX : h[COST_W-1:0];
	end

	logic [NW-1:0] start_c;
	assign start_c = cell_of(start_q);

	logic nb_wall;
	assign nb_wall = wall_q[nb_q];

	logic [COST_W-1:0] f_cur;
	assign f_cur = sat_add(g_rd_q, h_rd_q);

	assign req.ready = (state_q == S_IDLE) && !out_v_q;
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_v_q;
	assign rsp.payload = out_q;

	logic [NW-1:0] oidx;
	assign oidx = idx_q[NW-1:0];

	// memory ports: one read per memory per cycle
	logic [NW-1:0] sel_rd_cell;
	assign sel_rd_cell = open_rd_q;
	always_ff @(posedge clk) begin
		par_rd_q <= parent_mem[walk_q];
		open_rd_q <= open_mem[oidx];
		g_rd_q <= g_mem[(state_q == S_SELW || state_q == S_SEL) ? sel_rd_cell : nb_q];
		h_rd_q <= h_mem[sel_rd_cell];
		if (state_q == S_UPD && !closed_q[nb_q] && !nb_wall
				&& ((disc_q[nb_q] && sum_q < g_rd_q) || !found_q)) begin
			parent_mem[nb_q] <= cur_q;
			g_mem[nb_q] <= sum_q;
			h_mem[nb_q] <= heur;
		end
		if (state_q == S_UPD && !found_q && ocount_q < OCW'(NCELLS)
				&& !closed_q[nb_q] && !nb_wall)
			open_mem[ocount_q[NW-1:0]] <= nb_q;
		else if (state_q == S_SHIFTW)
			open_mem[pos_q] <= open_rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wall_q <= '0;
			start_q <= '0;
			finish_q <= 6'd63;
			disc_q <= '0;
			closed_q <= '0;
			ocount_q <= '0;
			out_v_q <= 1'b0;
			out_q <= '0;
			rt_q <= '0;
			cur_q <= '0;
			nb_q <= '0;
			idx_q <= '0;
			steps_q <= '0;
			found_q <= 1'b0;
			pos_q <= '0;
			walk_q <= '0;
			sum_q <= '0;
			pass_q <= 1'b0;
			bf_q <= '0;
			bh_q <= '0;
			bh_ok_q <= 1'b0;
			best_q <= '0;
			sel_cell_q <= '0;
		end else begin
			if (cfg.valid) begin
				unique case (cfg.payload.index)
					CFG_WALL:   wall_q <= cfg.payload.data;
					CFG_START:  start_q <= cfg.payload.data[CELL_W-1:0];
					CFG_FINISH: finish_q <= cfg.payload.data[CELL_W-1:0];
					default: ;
				endcase
			end
			if (out_v_q && rsp.ready) out_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						rt_q <= req.payload.req_type;
						cur_q <= cell_of(req.payload.current_cell);
						nb_q <= cell_of(req.payload.neighbour_cell);
						idx_q <= '0;
						found_q <= 1'b0;
						out_q <= '0;
						unique case (req_t'(req.payload.req_type)) inside
							REQ_DISCOVER, REQ_CLOSE: state_q <= S_FIND;
							REQ_SELECT: begin
								pass_q <= 1'b0;
								bf_q <= COST_MAX;
								bh_q <= COST_MAX;
								bh_ok_q <= 1'b0;
								best_q <= '0;
								state_q <= S_SEL;
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_FIND: begin
					if (rt_q == REQ_DISCOVER && (nb_wall || closed_q[nb_q])) begin
						if (nb_wall) out_q.status <= ST_WALL;
						state_q <= S_OUT;
					end else if (found_q || idx_q >= ocount_q) begin
						// prepare chain walk or shift; a close of a cell that is not open ends here
						if (rt_q == REQ_DISCOVER) begin
							walk_q <= nb_q;
							sum_q <= '0;
							steps_q <= '0;
							state_q <= S_CHAIN;
						end else begin
							closed_q[cur_q] <= 1'b1;
							if (found_q) begin
								idx_q <= OCW'(pos_q) + 1'b1;
								state_q <= S_SHIFT;
							end else state_q <= S_OUT;
						end
					end else state_q <= S_FINDW;
				end
				S_FINDW: begin
					if (open_rd_q == ((rt_q == REQ_DISCOVER) ? nb_q : cur_q)) begin
						found_q <= 1'b1;
						pos_q <= oidx;
					end else idx_q <= idx_q + 1'b1;
					state_q <= S_FIND;
				end
				S_CHAIN: begin
					if (walk_q == start_c || steps_q >= (OCW+1)'(NCELLS)) state_q <= S_UPD;
					else state_q <= S_CHAINW;
				end
				S_CHAINW: begin
					sum_q <= sat_add(sum_q, COST_W'(step_w));
					walk_q <= b_c;
					steps_q <= steps_q + 1'b1;
					state_q <= S_CHAIN;
				end
				S_UPD: begin
					// g_rd_q holds stored g of the neighbour here
					if ((disc_q[nb_q] && sum_q < g_rd_q) || !found_q) begin
						disc_q[nb_q] <= 1'b1;
						if (!found_q && ocount_q < OCW'(NCELLS)) ocount_q <= ocount_q + 1'b1;
					end
					state_q <= S_OUT;
				end
				S_SHIFT: begin
					if (idx_q >= ocount_q) begin
						ocount_q <= ocount_q - 1'b1;
						state_q <= S_OUT;
					end else state_q <= S_SHIFTW;
				end
				S_SHIFTW: begin
					pos_q <= pos_q + 1'b1;
					idx_q <= idx_q + 1'b1;
					state_q <= S_SHIFT;
				end
				S_SEL: begin
					if (ocount_q == '0) begin
						out_q.status <= ST_EMPTY;
						state_q <= S_OUT;
					end else if (idx_q >= ocount_q) begin
						if (pass_q) begin
							out_q.chosen_cell <= CELL_W'(best_q);
							out_q.chosen_cost <= bf_q;
							state_q <= S_OUT;
						end else begin
							pass_q <= 1'b1;
							idx_q <= '0;
						end
					end else state_q <= S_SELW;
					sel_cell_q <= open_rd_q;
				end
				S_SELW: begin
					// costs of the entry read last cycle are now present
					if (sel_cell_q == open_rd_q) begin
						if (!pass_q) begin
							if (f_cur < bf_q) bf_q <= f_cur;
						end else if (f_cur == bf_q && (!bh_ok_q || h_rd_q < bh_q)) begin
							bh_q <= h_rd_q;
							bh_ok_q <= 1'b1;
							best_q <= open_rd_q;
						end
						idx_q <= idx_q + 1'b1;
						state_q <= S_SEL;
					end else sel_cell_q <= open_rd_q;
				end
				S_OUT: begin
					out_v_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: tb/sv/gan_checker.sv
// Checker: predicts the A* node store from accepted transactions and compares results.
module gan_checker import gan_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	gan_req_if   req,
	gan_rsp_if   rsp,
	gan_cfg_if   cfg,
	output int   errors,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NCELL = 64;

	logic [63:0]       walls = '0;
	logic [CELL_W-1:0] start_ix = '0;
	logic [CELL_W-1:0] finish_ix = 6'd63;

	logic [CELL_W-1:0] parent_of [NCELL];
	logic              seen      [NCELL];
	logic              shut      [NCELL];
	logic [COST_W-1:0] g_cost    [NCELL];
	logic [COST_W-1:0] h_cost    [NCELL];
	logic [CELL_W-1:0] open_q    [NCELL];
	int                open_n = 0;

	rsp_item_t expected_rsp [$];

	initial begin
		errors = 0;
		pending = 0;
		for (int i = 0; i < NCELL; i++) begin
			parent_of[i] = '0;
			seen[i] = 1'b0;
			shut[i] = 1'b0;
			g_cost[i] = '0;
			h_cost[i] = '0;
			open_q[i] = '0;
		end
	end

	function automatic int sat(input int v);
		return (v > int'(COST_MAX)) ? int'(COST_MAX) : v;
	endfunction

	function automatic int move_cost(input int a, input int b);
		if ((a / 8 != b / 8) && (a % 8 != b % 8))
			return int'(STEP_DIAG);
		return int'(STEP_STRAIGHT);
	endfunction

	function automatic int octile_h(input int c);
		int dr, dc, lo, hi;
		dr = c / 8 - int'(finish_ix) / 8;
		dc = c % 8 - int'(finish_ix) % 8;
		if (dr < 0) dr = -dr;
		if (dc < 0) dc = -dc;
		lo = (dr < dc) ? dr : dc;
		hi = (dr < dc) ? dc : dr;
		return sat(int'(STEP_DIAG) * lo + int'(STEP_STRAIGHT) * (hi - lo));
	endfunction

	// g of 'from' with 'ovr' re-parented to 'via'; bounded to one lap of the grid
	function automatic int chain_g(input int from, input int ovr, input int via);
		int p, q, sum;
		p = from;
		sum = 0;
		for (int n = 0; n < NCELL && p != int'(start_ix); n++) begin
			q = (p == ovr) ? via : int'(parent_of[p]);
			sum = sat(sum + move_cost(p, q));
			p = q;
		end
		return sum;
	endfunction

	function automatic int open_pos(input int c);
		for (int i = 0; i < open_n; i++)
			if (int'(open_q[i]) == c)
				return i;
		return -1;
	endfunction

	task automatic apply_request(input req_item_t it, output rsp_item_t r);
		int cur, nb, pos, g_new, f, best, best_f, best_h;
		bit listed;
		cur = int'(it.current_cell);
		nb = int'(it.neighbour_cell);
		r = '0;
		r.status = ST_DONE;
		case (req_t'(it.req_type))
			REQ_DISCOVER: begin
				if (walls[nb]) begin
					r.status = ST_WALL;
				end else if (!shut[nb]) begin
					listed = open_pos(nb) >= 0;
					g_new = chain_g(nb, nb, cur);
					if ((seen[nb] && g_new < int'(g_cost[nb])) || !listed) begin
						parent_of[nb] = CELL_W'(cur);
						seen[nb] = 1'b1;
						h_cost[nb] = COST_W'(octile_h(nb));
						g_cost[nb] = COST_W'(g_new);
						if (!listed && open_n < NCELL) begin
							open_q[open_n] = CELL_W'(nb);
							open_n++;
						end
					end
				end
			end
			REQ_CLOSE: begin
				pos = open_pos(cur);
				shut[cur] = 1'b1;
				if (pos >= 0) begin
					for (int i = pos; i + 1 < open_n; i++)
						open_q[i] = open_q[i + 1];
					open_n--;
				end
			end
			REQ_SELECT: begin
				if (open_n == 0) begin
					r.status = ST_EMPTY;
				end else begin
					best = 0;
					best_f = int'(COST_MAX) + 1;
					best_h = int'(COST_MAX) + 1;
					for (int i = 0; i < open_n; i++) begin
						f = sat(int'(g_cost[open_q[i]]) + int'(h_cost[open_q[i]]));
						if (f < best_f) best_f = f;
					end
					// ties on f go to the first cell with the least h
					for (int i = 0; i < open_n; i++) begin
						f = sat(int'(g_cost[open_q[i]]) + int'(h_cost[open_q[i]]));
						if (f == best_f && int'(h_cost[open_q[i]]) < best_h) begin
							best_h = int'(h_cost[open_q[i]]);
							best = int'(open_q[i]);
						end
					end
					r.chosen_cell = CELL_W'(best);
					r.chosen_cost = COST_W'(best_f);
				end
			end
			default: ;
		endcase
	endtask

	task automatic report(input string what, input int got, input int want);
		$display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		rsp_item_t r, want;
		if (arst_n) begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.payload.index)
					CFG_WALL:   walls = cfg.payload.data;
					CFG_START:  start_ix = cfg.payload.data[CELL_W-1:0];
					CFG_FINISH: finish_ix = cfg.payload.data[CELL_W-1:0];
					default: ;
				endcase
			end
			if (req.valid && req.ready) begin
				apply_request(req.payload, r);
				expected_rsp.insert(expected_rsp.size(), r);
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_rsp.size() == 0) begin
					report("unexpected result transaction", 1, 0);
				end else begin
					want = expected_rsp.pop_front();
					if (rsp.payload.status !== want.status)
						report("status", int'(rsp.payload.status), int'(want.status));
					if (rsp.payload.chosen_cell !== want.chosen_cell)
						report("chosen_cell", int'(rsp.payload.chosen_cell),
								int'(want.chosen_cell));
					if (rsp.payload.chosen_cost !== want.chosen_cost)
						report("chosen_cost", int'(rsp.payload.chosen_cost),
								int'(want.chosen_cost));
				end
			end
		end
		pending <= expected_rsp.size();
	end
endmodule

FILE: tb/sv/tb_top.sv
// Testbench top: drives requests and configuration, stalls results, gives the verdict.
module tb_top;
	import gan_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 20000; // cycles without any transaction
	localparam int HOLD_OFF   = 300;   // quiet stretch after the last result comes back

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors, pending;

	gan_req_if req_ch ();
	gan_rsp_if rsp_ch ();
	gan_cfg_if cfg_ch ();

	grid_astar_node_engine i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	gan_checker i_chk (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.cfg     (cfg_ch),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Shadow of what the stimulus has already sent, so that a discover never walks a
	// parent chain through a cell whose parent was never written. Every cell on a
	// chain is either discovered or the start, and a start is discovered before the
	// start register moves away from it.
	logic [63:0]       sh_walls = '0;
	logic [CELL_W-1:0] sh_start = '0;
	bit                sh_seen [64];
	bit                sh_shut [64];
	int                burst_left = 0;

	// watchdog: any transaction on any channel restarts the count
	int quiet = 0;
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= IDLE_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// result side: switches between always ready, coin-flip stalls and a fixed pattern
	int rdy_mode = 0, rdy_left = 0, rdy_tick = 0;
	always @(posedge clk) begin
		if (rdy_left == 0) begin
			rdy_mode <= $urandom_range(0, 2);
			rdy_left <= $urandom_range(50, 400);
		end else begin
			rdy_left <= rdy_left - 1;
		end
		rdy_tick <= rdy_tick + 1;
		case (rdy_mode)
			0: rsp_ch.ready <= 1'b1;
			1: rsp_ch.ready <= 1'($urandom_range(0, 1));
			default: rsp_ch.ready <= (rdy_tick % 7) < 3; // ready while the tick count modulo 7 is below 3
		endcase
	end

	// track what a request does to the shadow before handing it over
	task automatic send_req(input req_item_t it);
		if (burst_left == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
			// some bursts are long enough to give stretches with no gaps
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) :
					$urandom_range(1, 12);
		end
		burst_left--;
		if (it.req_type == REQ_DISCOVER) begin
			if (!sh_walls[it.neighbour_cell] && !sh_shut[it.neighbour_cell])
				sh_seen[it.neighbour_cell] = 1'b1;
		end else if (it.req_type == REQ_CLOSE) begin
			sh_shut[it.current_cell] = 1'b1;
		end
		req_ch.valid <= 1'b1;
		req_ch.payload <= it;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
	endtask

	// sender holds off until every result is back and the block has gone quiet
	task automatic drain();
		req_ch.valid <= 1'b0;
		burst_left = 0;
		repeat (2) @(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (HOLD_OFF) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [1:0] idx, input logic [63:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.payload <= '{index: idx, data: data};
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		if (idx == CFG_WALL) sh_walls = data;
		if (idx == CFG_START) sh_start = data[CELL_W-1:0];
		@(posedge clk);
	endtask

	function automatic req_item_t mk(input req_t t, input int cur, input int nb);
		req_item_t it;
		it.req_type = t;
		it.current_cell = CELL_W'(cur);
		it.neighbour_cell = CELL_W'(nb);
		return it;
	endfunction

	// a cell that is safe to expand: the start or any discovered cell
	function automatic int pick_cur();
		int n, k;
		n = 0;
		for (int i = 0; i < 64; i++)
			if (sh_seen[i]) n++;
		k = $urandom_range(0, n);
		if (k == n) return int'(sh_start);
		for (int i = 0; i < 64; i++) begin
			if (sh_seen[i]) begin
				if (k == 0) return i;
				k--;
			end
		end
		return int'(sh_start);
	endfunction

	function automatic int step_toward(input int c);
		int r, k;
		r = c / 8 + $urandom_range(0, 2) - 1;
		k = c % 8 + $urandom_range(0, 2) - 1;
		if (r < 0 || r > 7 || k < 0 || k > 7) return $urandom_range(0, 63);
		return r * 8 + k;
	endfunction

	// closing an undiscovered start would strand it with an unwritten parent
	function automatic bit may_close(input int c);
		return !(c == int'(sh_start) && !sh_seen[c]);
	endfunction

	function automatic req_item_t random_item();
		int r, c;
		r = $urandom_range(0, 99);
		c = pick_cur();
		if (r < 55) return mk(REQ_DISCOVER, c, step_toward(c));
		if (r < 66) return mk(REQ_DISCOVER, c, $urandom_range(0, 63));
		if (r < 86) return mk(REQ_SELECT, $urandom_range(0, 63), $urandom_range(0, 63));
		if (r < 92) begin
			c = (r < 90) ? c : $urandom_range(0, 63);
			if (may_close(c))
				return mk(REQ_CLOSE, c, $urandom_range(0, 63));
			return mk(REQ_SELECT, 0, 0);
		end
		return mk(REQ_NONE, $urandom_range(0, 63), $urandom_range(0, 63));
	endfunction

	// new settings; the old start gets discovered (as its own parent) before it is left
	task automatic set_phase(input logic [63:0] walls, input int strt, input int fin);
		int s0;
		drain();
		s0 = int'(sh_start);
		if (strt != s0 && sh_shut[strt] && !sh_seen[strt]) strt = s0;
		if (strt != s0 && !sh_seen[s0]) begin
			if (sh_shut[s0]) begin
				strt = s0;
			end else begin
				if (sh_walls[s0]) cfg_write(CFG_WALL, sh_walls & ~(64'd1 << s0));
				send_req(mk(REQ_DISCOVER, s0, s0));
				drain();
			end
		end
		cfg_write(CFG_WALL, walls);
		cfg_write(CFG_START, 64'(strt));
		cfg_write(CFG_FINISH, 64'(fin));
	endtask

	function automatic logic [63:0] sparse_walls(input int one_in);
		logic [63:0] w;
		for (int i = 0; i < 64; i++)
			w[i] = ($urandom_range(1, one_in) == 1);
		return w;
	endfunction

	initial begin
		req_ch.valid <= 1'b0;
		req_ch.payload <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.payload <= '0;
		for (int i = 0; i < 64; i++) begin
			sh_seen[i] = 1'b0;
			sh_shut[i] = 1'b0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, on reset settings: start 0, finish 63, no walls
		send_req(mk(REQ_SELECT, 0, 0));        // empty open list
		send_req(mk(REQ_NONE, 63, 63));        // unused request type
		send_req(mk(REQ_DISCOVER, 0, 0));      // the start itself, g 0
		send_req(mk(REQ_DISCOVER, 0, 9));      // diagonal step
		send_req(mk(REQ_DISCOVER, 0, 1));      // straight step
		send_req(mk(REQ_DISCOVER, 1, 10));     // g 241
		send_req(mk(REQ_DISCOVER, 0, 10));     // cheaper: re-parent to g 141
		send_req(mk(REQ_DISCOVER, 9, 10));     // dearer: kept as is
		send_req(mk(REQ_SELECT, 0, 0));
		send_req(mk(REQ_CLOSE, 0, 0));
		send_req(mk(REQ_CLOSE, 50, 0));        // not open: only marked closed
		send_req(mk(REQ_DISCOVER, 9, 0));      // closed cell is skipped
		send_req(mk(REQ_DISCOVER, 0, 63));     // top index, on the finish
		send_req(mk(REQ_DISCOVER, 63, 62));
		send_req(mk(REQ_SELECT, 0, 0));
		send_req(mk(REQ_CLOSE, 63, 0));
		send_req(mk(REQ_SELECT, 0, 0));

		// walls around the expanded cells, finish on the start cell
		set_phase(64'h8000_0000_0000_0404, 0, 0);
		send_req(mk(REQ_DISCOVER, 1, 2));      // wall
		send_req(mk(REQ_DISCOVER, 10, 63));    // wall at top index
		send_req(mk(REQ_DISCOVER, 10, 11));
		send_req(mk(REQ_SELECT, 0, 0));
		send_req(mk(REQ_NONE, 0, 0));

		// random phases, extremes of every register among them
		set_phase(64'd0, 0, 63);
		repeat (170) send_req(random_item());
		set_phase(sparse_walls(8), $urandom_range(0, 63), $urandom_range(0, 63));
		repeat (170) send_req(random_item());
		set_phase({64{1'b1}}, 63, 0);
		repeat (40) send_req(random_item());
		set_phase(sparse_walls(2), $urandom_range(0, 63), 63);
		repeat (140) send_req(random_item());
		set_phase(sparse_walls(6), 0, $urandom_range(0, 63));
		repeat (150) send_req(random_item());
		set_phase(64'd0, $urandom_range(0, 63), 0);
		repeat (150) send_req(random_item());

		drain();
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
